// File: design/periodic_timer_bank_defines.svh
// Assertion macros for the periodic timer bank.
// Depends on nothing; included by files that assert.
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PTB_ASSERT_NEXT(label, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) else $error(msg);
`else
`define PTB_ASSERT(label, prop, msg)
`define PTB_ASSERT_NEXT(label, a, c, msg)
`endif
`endif

// File: design/ptb_pkg.sv
// Package for the periodic timer bank: beat types, codes, control structs.
// Depends on nothing.
package ptb_pkg;
	localparam int NUM_TIMERS = 8;
	localparam int IDX_W = $clog2(NUM_TIMERS);
	localparam logic [31:0] MS_PER_SEC = 32'd1000;
	// ceil(2^38 / 1000): x / 1000 == (x * SEC_RECIP) >> 38 for every 32-bit x
	localparam logic [28:0] SEC_RECIP = 29'd274877907;

	localparam logic [2:0] ACT_TICK   = 3'd0;
	localparam logic [2:0] ACT_CREATE = 3'd1;
	localparam logic [2:0] ACT_START  = 3'd2;
	localparam logic [2:0] ACT_STOP   = 3'd3;
	localparam logic [2:0] ACT_SETP   = 3'd4;
	localparam logic [2:0] ACT_QUERY  = 3'd5;

	localparam logic [1:0] KIND_MS    = 2'd0;
	localparam logic [1:0] KIND_SEC   = 2'd1;
	localparam logic [1:0] KIND_TICKS = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [2:0]  timer_index;
		logic [1:0]  timer_kind;
		logic [31:0] period_value;
		logic        repeat_mode;
		logic [31:0] now_ms;
		logic [31:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		logic        is_running;
		logic        is_expired;
		logic [31:0] elapsed;
		logic [31:0] period_readback;
		logic [7:0]  expired_mask;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_APPLY, ST_T_EVAL, ST_T_DIV, ST_T_FIN, ST_RB, ST_EMIT
	} state_t;

	typedef struct packed {
		logic             load;
		logic             apply;
		logic             eval;
		logic             fin;
		logic             rb_start;
		logic             emit;
		logic [IDX_W-1:0] ti;
	} cmd_t;

	typedef struct packed {
		logic req_tick;
		logic need_div;
		logic div_done;
	} status_t;
endpackage

// File: design/periodic_timer_bank.sv
// Top level of the periodic timer bank: controller plus datapath.
// Depends on ptb_pkg, ptb_ctrl, ptb_dp.
//
// Usage: drive one request beat (action, index, kind, period, repeat, time
// bases) with start high while busy is low; it is taken at that edge. busy
// stays high until the result beat, which appears on result for exactly one
// cycle with done high. The receiver cannot stall; sample result on done.
// Sequence: a create, start, stop, set period or query passes through the
// apply, readback and emit states; a seconds readback goes through a constant
// reciprocal multiply and adds no state. A tick walks all NUM_TIMERS timers one
// per cycle, but each repeating timer that has expired with a nonzero period
// stalls the walk in the bit-serial divider and a finish state to realign its
// start.
// Reset (arst_n low) clears all timer tables and latched time bases at once;
// the controller resets to idle, so the block is ready as soon as reset ends.
module periodic_timer_bank import ptb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      done,
	output out_item_t result
);
	cmd_t    cmd;
	status_t st;

	// sequence the work for each accepted beat
	ptb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .busy(busy), .cmd(cmd)
	);

	// hold the tables and produce the result beat
	ptb_dp u_dp (
		.clk(clk), .arst_n(arst_n), .request(request), .cmd(cmd), .st(st),
		.done(done), .result(result)
	);
endmodule

// File: design/ptb_div.sv
// Restoring 32-bit divider, one quotient bit per cycle; yields the remainder.
// Depends on nothing.
module ptb_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] rem
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        run_q, done_q;
	logic [32:0] trial, diff;
	logic        ge;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// File: design/ptb_dp.sv
// Datapath of the timer bank: timer tables, time bases, divider, result register.
// Depends on ptb_pkg and ptb_div.
module ptb_dp import ptb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  request,
	input  cmd_t      cmd,
	output status_t   st,
	output logic      done,
	output out_item_t result
);
	logic [1:0]  kind_q    [NUM_TIMERS];
	logic        rep_q     [NUM_TIMERS];
	logic        run_q     [NUM_TIMERS];
	logic        exp_q     [NUM_TIMERS];
	logic        lst_q     [NUM_TIMERS];
	logic [31:0] period_q  [NUM_TIMERS];
	logic [31:0] start_q   [NUM_TIMERS];
	logic [31:0] elapsed_q [NUM_TIMERS];
	logic [31:0] lat_ms_q, lat_ticks_q, d_q, rb_q;
	in_item_t    req_q;
	out_item_t   result_q;
	logic        done_q;

	logic [IDX_W-1:0] idx;
	logic             ok;
	logic [31:0]      d, ti_period;
	logic             div_go, div_done;
	logic [31:0]      div_num, div_den, div_rem;
	logic [7:0]       mask;
	logic             rb_sec;
	logic [60:0]      rb_prod;

	function automatic logic [31:0] time_base(logic [1:0] k, logic [31:0] ms, logic [31:0] tk);
		logic [31:0] r;
		case (k)
			KIND_MS, KIND_SEC: r = ms;
			KIND_TICKS:        r = tk;
			default:           r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] scale(logic [1:0] k, logic [31:0] p);
		return (k == KIND_SEC) ? p * MS_PER_SEC : p;
	endfunction

	assign idx       = req_q.timer_index[IDX_W-1:0];
	assign ok        = 32'(req_q.timer_index) < NUM_TIMERS;
	assign ti_period = period_q[cmd.ti];
	assign d         = time_base(kind_q[cmd.ti], lat_ms_q, lat_ticks_q) - start_q[cmd.ti];

	assign st.req_tick = request.action == ACT_TICK;
	assign st.need_div = lst_q[cmd.ti] && run_q[cmd.ti] && (d >= ti_period)
		&& rep_q[cmd.ti] && (ti_period != 32'd0);
	assign st.div_done = div_done;

	// seconds readback: divide by 1000 through the reciprocal, keep bits 60:38
	assign rb_sec  = ok && (kind_q[idx] == KIND_SEC);
	assign rb_prod = 61'(period_q[idx]) * 61'(SEC_RECIP);

	assign div_go  = cmd.eval && st.need_div;
	assign div_num = d;
	assign div_den = ti_period;

	ptb_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .num(div_num), .den(div_den),
		.done(div_done), .rem(div_rem)
	);

	always_comb begin
		mask = '0;
		for (int i = 0; i < NUM_TIMERS && i < 8; i++) mask[i] = exp_q[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= request;
		if (cmd.eval) d_q <= d;
		if (cmd.rb_start) rb_q <= rb_sec ? {9'd0, rb_prod[60:38]} : period_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				kind_q[i] <= '0; rep_q[i] <= 1'b0; run_q[i] <= 1'b0;
				exp_q[i] <= 1'b0; lst_q[i] <= 1'b0; period_q[i] <= '0;
				start_q[i] <= '0; elapsed_q[i] <= '0;
			end
			lat_ms_q    <= '0;
			lat_ticks_q <= '0;
		end else begin
			if (cmd.load && st.req_tick) begin
				lat_ms_q    <= request.now_ms;
				lat_ticks_q <= request.now_ticks;
			end
			if (cmd.eval && lst_q[cmd.ti]) begin
				if (!run_q[cmd.ti]) begin
					lst_q[cmd.ti] <= 1'b0;
					exp_q[cmd.ti] <= 1'b0;
				end else if (d >= ti_period) begin
					exp_q[cmd.ti] <= 1'b1;
					if (rep_q[cmd.ti]) begin
						elapsed_q[cmd.ti] <= d;
					end else begin
						elapsed_q[cmd.ti] <= '0;
						run_q[cmd.ti]     <= 1'b0;
					end
				end else begin
					elapsed_q[cmd.ti] <= d;
					exp_q[cmd.ti]     <= 1'b0;
				end
			end
			// advance start by whole periods: d - (d mod period)
			if (cmd.fin) start_q[cmd.ti] <= start_q[cmd.ti] + d_q - div_rem;
			if (cmd.apply && ok) begin
				case (req_q.action)
					ACT_CREATE: begin
						kind_q[idx]    <= req_q.timer_kind;
						rep_q[idx]     <= req_q.repeat_mode;
						run_q[idx]     <= 1'b0;
						exp_q[idx]     <= 1'b0;
						lst_q[idx]     <= 1'b0;
						period_q[idx]  <= scale(req_q.timer_kind, req_q.period_value);
						start_q[idx]   <= '0;
						elapsed_q[idx] <= '0;
					end
					ACT_START: begin
						start_q[idx]   <= time_base(kind_q[idx], lat_ms_q, lat_ticks_q);
						elapsed_q[idx] <= '0;
						run_q[idx]     <= 1'b1;
						exp_q[idx]     <= period_q[idx] == 32'd0;
						lst_q[idx]     <= 1'b1;
					end
					ACT_STOP: begin
						elapsed_q[idx] <= '0;
						run_q[idx]     <= 1'b0;
						exp_q[idx]     <= 1'b0;
						lst_q[idx]     <= 1'b0;
					end
					ACT_SETP: begin
						period_q[idx] <= scale(kind_q[idx], req_q.period_value);
						if (scale(kind_q[idx], req_q.period_value) == 32'd0 && run_q[idx])
							exp_q[idx] <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.expired_mask <= mask;
			if (ok) begin
				result_q.is_running      <= run_q[idx];
				result_q.is_expired      <= exp_q[idx];
				result_q.elapsed         <= elapsed_q[idx];
				result_q.period_readback <= rb_q;
			end else begin
				result_q.is_running      <= 1'b0;
				result_q.is_expired      <= 1'b0;
				result_q.elapsed         <= '0;
				result_q.period_readback <= '0;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

// File: design/ptb_ctrl.sv
// Controller of the timer bank: sequences actions, the tick walk and readback.
// Depends on ptb_pkg and periodic_timer_bank_defines.svh.
`include "periodic_timer_bank_defines.svh"
module ptb_ctrl import ptb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t st,
	output logic    busy,
	output cmd_t    cmd
);
	state_t           state_q, state_d;
	logic [IDX_W-1:0] ti_q, ti_d;
	logic             last;

	assign last = 32'(ti_q) == NUM_TIMERS - 1;
	assign busy = state_q != ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ti_q    <= '0;
		end else begin
			state_q <= state_d;
			ti_q    <= ti_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ti_d    = ti_q;
		cmd     = '0;
		cmd.ti  = ti_q;
		case (state_q)
			ST_IDLE: if (start) begin
				cmd.load = 1'b1;
				ti_d     = '0;
				state_d  = st.req_tick ? ST_T_EVAL : ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_RB;
			end
			ST_T_EVAL: begin
				cmd.eval = 1'b1;
				if (st.need_div) state_d = ST_T_DIV;
				else if (last) state_d = ST_RB;
				else ti_d = ti_q + 1'b1;
			end
			ST_T_DIV: if (st.div_done) state_d = ST_T_FIN;
			ST_T_FIN: begin
				cmd.fin = 1'b1;
				if (last) state_d = ST_RB;
				else begin
					ti_d    = ti_q + 1'b1;
					state_d = ST_T_EVAL;
				end
			end
			ST_RB: begin
				cmd.rb_start = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PTB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
	`PTB_ASSERT_NEXT(a_emit_idle, cmd.emit, !busy, "controller not idle after emit")
	`PTB_ASSERT_NEXT(a_div_hold, state_q == ST_T_DIV && !st.div_done, state_q == ST_T_DIV,
		"left divide wait early")
	`PTB_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.apply, cmd.eval, cmd.fin, cmd.rb_start,
		cmd.emit}), "overlapping datapath commands")
endmodule
